// ===== hw/rtl/lhid_pkg.sv =====
// Shared types, constants and helper functions for the lowest-hole identifier allocator.
`timescale 1ns / 1ps

package lhid_pkg;

	localparam int MAX_IDS   = 256;
	localparam int ID_W      = 9;
	localparam int STATUS_W  = 2;
	localparam int SEG_W     = 32;
	localparam int SEG_IDX_W = $clog2(SEG_W);
	localparam int NUM_CELLS = MAX_IDS / SEG_W;
	localparam int CELL_W    = $clog2(NUM_CELLS);
	localparam int IDX_W     = CELL_W + SEG_IDX_W;
	localparam int MARK_W    = $clog2(MAX_IDS + 1);
	localparam int CMP_W     = (MARK_W > ID_W) ? MARK_W : ID_W;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY       = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_RELEASE = 2'd2;

	typedef struct packed {
		logic            operation;
		logic [ID_W-1:0] release_id;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0]     granted_id;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	typedef enum logic [1:0] {
		UPD_NONE,
		UPD_SET,
		UPD_CLEAR,
		UPD_CLEAR_FROM
	} upd_op_t;

	// Map update broadcast to every cell.
	typedef struct packed {
		upd_op_t          op;
		logic [IDX_W-1:0] idx;
	} upd_t;

	// Scan token handed from cell to cell, lowest segment first.
	typedef struct packed {
		logic             valid;
		logic             low_found;
		logic [IDX_W-1:0] low_idx;
		logic             free_found;
		logic [IDX_W-1:0] free_idx;
		logic             rid_hole;
	} token_t;

	function automatic logic [SEG_IDX_W-1:0] lowest_set(input logic [SEG_W-1:0] v);
		logic [SEG_IDX_W-1:0] r;
		r = '0;
		for (int j = SEG_W - 1; j >= 0; j--) begin
			if (v[j]) begin
				r = SEG_IDX_W'(j);
			end
		end
		return r;
	endfunction

	function automatic logic [SEG_IDX_W-1:0] highest_set(input logic [SEG_W-1:0] v);
		logic [SEG_IDX_W-1:0] r;
		r = '0;
		for (int j = 0; j < SEG_W; j++) begin
			if (v[j]) begin
				r = SEG_IDX_W'(j);
			end
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/lhid_cell.sv =====
// One segment of the hole map with its stage of the scan chain.
`timescale 1ns / 1ps

module lhid_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [lhid_pkg::CELL_W-1:0] cell_idx,
	input  logic [lhid_pkg::CMP_W-1:0]  rid,
	input  lhid_pkg::upd_t              upd,
	input  lhid_pkg::token_t            tok_in,
	output lhid_pkg::token_t            tok_out
);

	logic [lhid_pkg::SEG_W-1:0] seg_q;
	logic [lhid_pkg::SEG_W-1:0] seg_d;
	logic [lhid_pkg::SEG_W-1:0] below;
	logic [lhid_pkg::SEG_W-1:0] free_cand;
	logic [lhid_pkg::CMP_W-1:0] rid_m1;
	logic                       rid_hit;
	lhid_pkg::token_t           tok_d;
	lhid_pkg::token_t           tok_q;

	// Bits whose identifier lies strictly below the released identifier.
	always_comb begin
		for (int j = 0; j < lhid_pkg::SEG_W; j++) begin
			below[j] = (lhid_pkg::CMP_W'({cell_idx, lhid_pkg::SEG_IDX_W'(j)})
				+ lhid_pkg::CMP_W'(1)) < rid;
		end
	end

	assign free_cand = ~seg_q & below;
	assign rid_m1    = rid - lhid_pkg::CMP_W'(1);
	assign rid_hit   = (rid != '0) &&
		((rid_m1 >> lhid_pkg::SEG_IDX_W) == lhid_pkg::CMP_W'(cell_idx));

	always_comb begin
		tok_d = tok_in;
		if (!tok_in.low_found && (seg_q != '0)) begin
			tok_d.low_found = 1'b1;
			tok_d.low_idx   = {cell_idx, lhid_pkg::lowest_set(seg_q)};
		end
		// A higher segment overrides what lower segments found.
		if (free_cand != '0) begin
			tok_d.free_found = 1'b1;
			tok_d.free_idx   = {cell_idx, lhid_pkg::highest_set(free_cand)};
		end
		tok_d.rid_hole = tok_in.rid_hole |
			(rid_hit & seg_q[rid_m1[lhid_pkg::SEG_IDX_W-1:0]]);
	end

	always_comb begin
		seg_d = seg_q;
		for (int j = 0; j < lhid_pkg::SEG_W; j++) begin
			case (upd.op)
				lhid_pkg::UPD_SET: begin
					if (upd.idx == {cell_idx, lhid_pkg::SEG_IDX_W'(j)}) begin
						seg_d[j] = 1'b1;
					end
				end
				lhid_pkg::UPD_CLEAR: begin
					if (upd.idx == {cell_idx, lhid_pkg::SEG_IDX_W'(j)}) begin
						seg_d[j] = 1'b0;
					end
				end
				lhid_pkg::UPD_CLEAR_FROM: begin
					if ({cell_idx, lhid_pkg::SEG_IDX_W'(j)} >= upd.idx) begin
						seg_d[j] = 1'b0;
					end
				end
				default: begin
					seg_d[j] = seg_q[j];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= '0;
			tok_q <= '0;
		end else begin
			seg_q       <= seg_d;
			tok_q.valid <= tok_in.valid;
			if (tok_in.valid) begin
				tok_q.low_found  <= tok_d.low_found;
				tok_q.low_idx    <= tok_d.low_idx;
				tok_q.free_found <= tok_d.free_found;
				tok_q.free_idx   <= tok_d.free_idx;
				tok_q.rid_hole   <= tok_d.rid_hole;
			end
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== hw/rtl/lowest_hole_id_allocator_unit.sv =====
// Top level of the lowest-hole identifier allocator: control, mark register and cell chain.
`timescale 1ns / 1ps

// Each transaction passes from acceptance to its response through the launch token, each cell of
// the eight-cell chain, the register that captures the scan result and the decision register.
// The next request is taken the cycle after the decision, so requests never overlap and the
// scan chain length sets the throughput. A response held by a stalled consumer delays the
// decision. Reset clears the hole map and the high-water mark at once; no clearing pass.

module lowest_hole_id_allocator_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  lhid_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output lhid_pkg::rsp_t rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE
	} state_t;

	state_t                      state_q;
	lhid_pkg::req_t              req_q;
	lhid_pkg::token_t            start_q;
	lhid_pkg::token_t            fin_q;
	lhid_pkg::upd_t              upd_q;
	logic [lhid_pkg::MARK_W-1:0] mark_q;
	logic                        rsp_valid_q;
	lhid_pkg::rsp_t              rsp_q;

	lhid_pkg::token_t            chain [lhid_pkg::NUM_CELLS+1];
	logic [lhid_pkg::CMP_W-1:0]  rid_c;
	logic [lhid_pkg::CMP_W-1:0]  mark_c;
	logic                        accept;
	logic                        rsp_free;
	logic                        decide_fire;

	lhid_pkg::rsp_t              dec_rsp;
	lhid_pkg::upd_t              dec_upd;
	logic [lhid_pkg::MARK_W-1:0] dec_mark;
	logic [lhid_pkg::MARK_W-1:0] walk_mark;

	assign req_stall   = (state_q != S_IDLE);
	assign accept      = req_valid && !req_stall;
	assign rsp_free    = !rsp_valid_q || !rsp_stall;
	// The decision waits until the output register can take the new response.
	assign decide_fire = (state_q == S_DECIDE) && rsp_free;
	assign rid_c       = lhid_pkg::CMP_W'(req_q.release_id);
	assign mark_c      = lhid_pkg::CMP_W'(mark_q);

	assign chain[0] = start_q;

	for (genvar k = 0; k < lhid_pkg::NUM_CELLS; k++) begin : g_cell
		lhid_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (lhid_pkg::CELL_W'(k)),
			.rid      (rid_c),
			.upd      (upd_q),
			.tok_in   (chain[k]),
			.tok_out  (chain[k+1])
		);
	end

	// New mark after the mark itself is released: the highest non-hole below it, or zero.
	assign walk_mark = fin_q.free_found ?
		(lhid_pkg::MARK_W'(fin_q.free_idx) + lhid_pkg::MARK_W'(1)) : '0;

	always_comb begin
		dec_rsp.granted_id = '0;
		dec_rsp.status     = lhid_pkg::ST_OK;
		dec_upd.op         = lhid_pkg::UPD_NONE;
		dec_upd.idx        = '0;
		dec_mark           = mark_q;
		if (req_q.operation == lhid_pkg::OP_ALLOC) begin
			if (fin_q.low_found) begin
				dec_rsp.granted_id = lhid_pkg::ID_W'(lhid_pkg::MARK_W'(fin_q.low_idx)
					+ lhid_pkg::MARK_W'(1));
				dec_upd.op  = lhid_pkg::UPD_CLEAR;
				dec_upd.idx = fin_q.low_idx;
			end else if (mark_q == lhid_pkg::MARK_W'(lhid_pkg::MAX_IDS)) begin
				dec_rsp.status = lhid_pkg::ST_EMPTY;
			end else begin
				dec_mark           = mark_q + lhid_pkg::MARK_W'(1);
				dec_rsp.granted_id = lhid_pkg::ID_W'(mark_q + lhid_pkg::MARK_W'(1));
			end
		end else begin
			if ((rid_c == '0) || (rid_c > mark_c) || fin_q.rid_hole) begin
				dec_rsp.status = lhid_pkg::ST_BAD_RELEASE;
			end else if (rid_c == mark_c) begin
				dec_mark    = walk_mark;
				dec_upd.op  = lhid_pkg::UPD_CLEAR_FROM;
				dec_upd.idx = lhid_pkg::IDX_W'(walk_mark);
			end else begin
				dec_upd.op  = lhid_pkg::UPD_SET;
				dec_upd.idx = lhid_pkg::IDX_W'(rid_c - lhid_pkg::CMP_W'(1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= '0;
			start_q     <= '0;
			fin_q       <= '0;
			upd_q       <= '0;
			mark_q      <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// Only the valid bit of the launch token ever changes after reset.
			start_q.valid <= accept;
			if (decide_fire) begin
				rsp_q       <= dec_rsp;
				rsp_valid_q <= 1'b1;
				upd_q       <= dec_upd;
				mark_q      <= dec_mark;
			end else begin
				upd_q.op <= lhid_pkg::UPD_NONE;
				if (rsp_valid_q && !rsp_stall) begin
					rsp_valid_q <= 1'b0;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q   <= req;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (chain[lhid_pkg::NUM_CELLS].valid) begin
						fin_q   <= chain[lhid_pkg::NUM_CELLS];
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== tb/lowest_hole_id_allocator_unit_tb.sv =====
// Self-checking testbench for the lowest-hole identifier allocator top level.
`timescale 1ns / 1ps

module lowest_hole_id_allocator_unit_tb;
	import lhid_pkg::*;

	localparam int NUM_ITEMS     = 2000;
	localparam int SETTLE_CYCLES = 30;

	typedef struct {
		req_t stim;
		bit   typed;
		rsp_t want;
	} dir_row_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	lowest_hole_id_allocator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Shadow copy of the allocator state.
	bit          hole_map [1:MAX_IDS];
	int unsigned high_mark  = 0;
	int unsigned hole_count = 0;
	int unsigned last_walk  = 0;

	rsp_t     expected_grants [$];
	dir_row_t directed_rows [$];
	bit       fixed_on  = 1'b0;
	rsp_t     fixed_rsp = '0;

	int send_idle_pct = 9;
	int rcv_idle_pct  = 74;
	int phase         = 0;
	int sent          = 0;
	int errors        = 0;
	int n_granted     = 0;
	int n_exhausted   = 0;
	int n_bad_release = 0;
	int n_released    = 0;
	int longest_walk  = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
	end

	function automatic rsp_t apply_id_request(input req_t r);
		rsp_t        o;
		int unsigned id;
		int unsigned h;
		o.granted_id = '0;
		o.status     = ST_OK;
		last_walk    = 0;
		h            = 0;
		if (r.operation == OP_ALLOC) begin
			for (id = 1; id < high_mark; id++) begin
				if (hole_map[id]) begin
					h = id;
					break;
				end
			end
			if (h != 0) begin
				hole_map[h] = 1'b0;
				hole_count--;
				o.granted_id = ID_W'(h);
			end else if (high_mark >= MAX_IDS) begin
				o.status = ST_EMPTY;
			end else begin
				high_mark++;
				o.granted_id = ID_W'(high_mark);
			end
		end else begin
			id = r.release_id;
			if (id == 0 || id > high_mark || hole_map[id]) begin
				o.status = ST_BAD_RELEASE;
			end else if (id == high_mark) begin
				// Lowering the mark swallows every hole sitting directly below it.
				high_mark--;
				while (high_mark > 0 && hole_map[high_mark]) begin
					hole_map[high_mark] = 1'b0;
					hole_count--;
					high_mark--;
					last_walk++;
				end
			end else begin
				hole_map[id] = 1'b1;
				hole_count++;
			end
		end
		return o;
	endfunction

	always @(posedge clk) begin : port_check
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_grants.size() == 0) begin
					$display("%0t: response with none expected: granted_id=%0d status=%0d",
						$time, rsp.granted_id, rsp.status);
					errors++;
				end else begin
					want = expected_grants.pop_front();
					if (rsp.granted_id !== want.granted_id) begin
						$display("%0t: granted_id mismatch: expected %0d, actual %0d",
							$time, want.granted_id, rsp.granted_id);
						errors++;
					end
					if (rsp.status !== want.status) begin
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, want.status, rsp.status);
						errors++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				want = apply_id_request(req);
				if (want.status == ST_EMPTY) begin
					n_exhausted++;
				end else if (want.status == ST_BAD_RELEASE) begin
					n_bad_release++;
				end else if (req.operation == OP_ALLOC) begin
					n_granted++;
				end else begin
					n_released++;
				end
				if (last_walk > longest_walk) begin
					longest_walk = last_walk;
				end
				if (fixed_on) begin
					want = fixed_rsp;
				end
				expected_grants.push_back(want);
			end
		end
	end

	task automatic add_row(input logic op, input int id, input bit typed, input int gid,
			input logic [STATUS_W-1:0] st);
		dir_row_t row;
		row.stim.operation  = op;
		row.stim.release_id = ID_W'(id);
		row.typed           = typed;
		row.want.granted_id = ID_W'(gid);
		row.want.status     = st;
		directed_rows.push_back(row);
	endtask

	// Holds the request side low until every outstanding transaction has answered.
	task automatic wait_for_quiet();
		req_valid <= 1'b0;
		do @(negedge clk); while (expected_grants.size() != 0);
	endtask

	task automatic send(input req_t item, input bit typed, input rsp_t want);
		if (phase == 0 && sent >= NUM_ITEMS / 3) begin
			wait_for_quiet();
			send_idle_pct = 74;
			rcv_idle_pct  = 9;
			phase         = 1;
		end else if (phase == 1 && sent >= 2 * NUM_ITEMS / 3) begin
			wait_for_quiet();
			send_idle_pct = 0;
			rcv_idle_pct  = 0;
			phase         = 2;
		end
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		fixed_on  = typed;
		fixed_rsp = want;
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (req_stall);
		sent++;
		@(negedge clk);
	endtask

	function automatic req_t alloc_item();
		req_t r;
		r.operation  = OP_ALLOC;
		r.release_id = ID_W'($urandom);
		return r;
	endfunction

	function automatic req_t good_release(input bit at_mark);
		req_t        r;
		int unsigned id;
		if (high_mark == 0) begin
			return alloc_item();
		end
		id = at_mark ? high_mark : $urandom_range(high_mark, 1);
		// The mark itself is never a hole, so this walk always stops.
		while (hole_map[id]) begin
			id++;
		end
		r.operation  = OP_RELEASE;
		r.release_id = ID_W'(id);
		return r;
	endfunction

	function automatic req_t bad_release();
		req_t        r;
		int unsigned holes [$];
		r.operation  = OP_RELEASE;
		r.release_id = ID_W'($urandom);
		case ($urandom_range(3))
			0: begin
				r.release_id = '0;
			end
			1: begin
				r.release_id = ID_W'($urandom_range(511, high_mark + 1));
			end
			2: begin
				for (int unsigned id = 1; id < high_mark; id++) begin
					if (hole_map[id]) begin
						holes.push_back(id);
					end
				end
				if (holes.size() != 0) begin
					r.release_id = ID_W'(holes[$urandom_range(holes.size() - 1)]);
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	initial begin : stimulus
		int   seq;
		int   n;
		int   pick;
		rsp_t none;
		none = '0;
		for (int i = 1; i <= MAX_IDS; i++) begin
			hole_map[i] = 1'b0;
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		add_row(OP_RELEASE, 0,   1, 0, ST_BAD_RELEASE);
		add_row(OP_RELEASE, 1,   1, 0, ST_BAD_RELEASE);
		add_row(OP_ALLOC,   0,   1, 1, ST_OK);
		add_row(OP_ALLOC,   0,   1, 2, ST_OK);
		add_row(OP_ALLOC,   0,   1, 3, ST_OK);
		add_row(OP_ALLOC,   0,   1, 4, ST_OK);
		add_row(OP_RELEASE, 2,   1, 0, ST_OK);
		add_row(OP_RELEASE, 2,   1, 0, ST_BAD_RELEASE);
		add_row(OP_RELEASE, 511, 1, 0, ST_BAD_RELEASE);
		add_row(OP_RELEASE, 256, 1, 0, ST_BAD_RELEASE);
		add_row(OP_ALLOC,   511, 1, 2, ST_OK);
		add_row(OP_RELEASE, 1,   1, 0, ST_OK);
		add_row(OP_RELEASE, 3,   1, 0, ST_OK);
		add_row(OP_RELEASE, 4,   0, 0, ST_OK);
		add_row(OP_ALLOC,   0,   0, 0, ST_OK);
		add_row(OP_RELEASE, 1,   0, 0, ST_OK);
		add_row(OP_RELEASE, 2,   0, 0, ST_OK);
		add_row(OP_RELEASE, 1,   1, 0, ST_BAD_RELEASE);
		add_row(OP_ALLOC,   0,   1, 1, ST_OK);
		add_row(OP_ALLOC,   0,   1, 2, ST_OK);
		add_row(OP_RELEASE, 2,   1, 0, ST_OK);
		add_row(OP_RELEASE, 1,   1, 0, ST_OK);
		add_row(OP_RELEASE, 1,   1, 0, ST_BAD_RELEASE);

		foreach (directed_rows[i]) begin
			send(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
		end
		wait_for_quiet();

		seq = 0;
		while (sent < NUM_ITEMS) begin
			seq++;
			if (seq == 1 || $urandom_range(9) == 0) begin
				// Fill to capacity, ask past it, then punch holes back in.
				while (!(high_mark == MAX_IDS && hole_count == 0)) begin
					send(alloc_item(), 1'b0, none);
				end
				repeat ($urandom_range(3, 1)) send(alloc_item(), 1'b0, none);
				repeat ($urandom_range(40, 10)) send(good_release(1'b0), 1'b0, none);
			end else if ($urandom_range(1) == 0) begin
				n = $urandom_range(60, 20);
				repeat (n) begin
					pick = $urandom_range(99);
					if (pick < 45) begin
						send(alloc_item(), 1'b0, none);
					end else if (pick < 90) begin
						send(good_release(1'b0), 1'b0, none);
					end else begin
						send(bad_release(), 1'b0, none);
					end
				end
			end else begin
				n = $urandom_range(50, 10);
				repeat (n) begin
					pick = $urandom_range(99);
					if (pick < 60) begin
						send(good_release(1'b1), 1'b0, none);
					end else if (pick < 85) begin
						send(good_release(1'b0), 1'b0, none);
					end else begin
						send(bad_release(), 1'b0, none);
					end
				end
			end
		end

		wait_for_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d requests: %0d grants, %0d exhausted, %0d releases, %0d rejected.",
			sent, n_granted, n_exhausted, n_released, n_bad_release);
		$display("Longest run of holes swallowed by a single mark release: %0d.", longest_walk);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Run did not finish in time.");
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== lowest_hole_id_allocator_unit.f =====
hw/rtl/lhid_pkg.sv
hw/rtl/lhid_cell.sv
hw/rtl/lowest_hole_id_allocator_unit.sv
tb/lowest_hole_id_allocator_unit_tb.sv
